### rtl/bb3_pkg.sv
package bb3_pkg;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	typedef struct packed {
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
		logic       frame_start;
	} pix_word_t;

	typedef struct packed {
		logic [7:0]  red_avg;
		logic [7:0]  green_avg;
		logic [7:0]  blue_avg;
		logic [9:0]  center_col;
		logic [11:0] center_row;
		logic        frame_last;
	} res_word_t;

	localparam int RGB_W = $bits(rgb_t);

	// configuration port
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 12;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

	localparam int FW_W = 11;
	localparam int ROW_W = 12;
	localparam logic [FW_W-1:0] FRAME_WIDTH_RST = 11'd640;
	localparam logic [ROW_W-1:0] FRAME_HEIGHT_RST = 12'd480;
	localparam logic [ROW_W-1:0] MIN_HEIGHT = 12'd3;

	// sum of nine 8-bit samples fits in 12 bits; x/9 == (x*3641)>>15 for x < 32768
	localparam int SUM_W = 12;
	localparam logic [SUM_W-1:0] RECIP_NINE = 12'd3641;
	localparam int RECIP_SHIFT = 15;

endpackage

### rtl/box_blur_3x3_rgb.sv
// channel | dir | handshake             | word
// pix     | in  | pix_valid / pix_ready | pix_data   (pix_word_t)
// res     | out | res_valid / res_ready | res_data   (res_word_t)
// cfg     | in  | cfg_we (no wait)      | cfg_index, cfg_data
//
// One pixel per clock sustained while res_ready keeps up; a result leaves by way of the stages below.
// Stages: s1 line-store read (registered RAM read), s2 window sums,
// output register holds the divide-by-nine product.
// The two line stores are read and written once per pixel; a read that hits
// the column being written in the same cycle is forwarded.
// arst_n clears valid flags and counters and sets the frame size registers to 640 x 480.
// A stall on res_ready backs up stage by stage; pix_ready drops only when all
// stages are full.
module box_blur_3x3_rgb
	import bb3_pkg::*;
#(
	parameter int MAX_LINE_PIXELS = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pix_valid,
	output logic                  pix_ready,
	input  pix_word_t             pix_data,
	output logic                  res_valid,
	input  logic                  res_ready,
	output res_word_t             res_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CW = $clog2(MAX_LINE_PIXELS);
	localparam int WW = $clog2(MAX_LINE_PIXELS + 1);
	localparam int CMPW = (WW > FW_W) ? WW : FW_W;

	// configuration
	logic [FW_W-1:0]  frame_width_q;
	logic [ROW_W-1:0] frame_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data[FW_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data[ROW_W-1:0];
				default: ;
			endcase
		end
	end

	logic [CMPW-1:0]  fw_ext;
	logic [WW-1:0]    w_use;
	logic [ROW_W-1:0] h_use;

	always_comb begin
		fw_ext = CMPW'(frame_width_q);
		if (fw_ext < CMPW'(3)) begin
			w_use = WW'(3);
		end else if (fw_ext > CMPW'(MAX_LINE_PIXELS)) begin
			w_use = WW'(MAX_LINE_PIXELS);
		end else begin
			w_use = WW'(fw_ext);
		end
		h_use = (frame_height_q < MIN_HEIGHT) ? MIN_HEIGHT : frame_height_q;
	end

	// handshake chain
	logic s1_valid_q, s2_valid_q, out_valid_q;
	logic out_free, s2_free, s2_go, s1_go, accept;

	assign out_free  = !out_valid_q || res_ready;
	assign s2_go     = s2_valid_q && out_free;
	assign s2_free   = !s2_valid_q || out_free;
	assign s1_go     = s1_valid_q && s2_free;
	assign pix_ready = !s1_valid_q || s2_free;
	assign accept    = pix_valid && pix_ready;

	// position tracking
	logic [CW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;
	logic [CW-1:0]    c0, c1;
	logic [ROW_W-1:0] r0, r2;
	logic [ROW_W:0]   r1, rn;
	logic [WW-1:0]    cn;
	logic [CW-1:0]    col_next;
	logic [ROW_W-1:0] row_next;
	logic             produce, last;

	always_comb begin
		c0 = pix_data.frame_start ? '0 : col_q;
		r0 = pix_data.frame_start ? '0 : row_q;
		if (WW'(c0) >= w_use) begin
			c1 = '0;
			r1 = (ROW_W+1)'(r0) + 1'b1;
		end else begin
			c1 = c0;
			r1 = (ROW_W+1)'(r0);
		end
		r2 = (r1 >= (ROW_W+1)'(h_use)) ? '0 : r1[ROW_W-1:0];

		cn = WW'(c1) + 1'b1;
		rn = (ROW_W+1)'(r2) + 1'b1;
		if (cn >= w_use) begin
			col_next = '0;
			row_next = (rn >= (ROW_W+1)'(h_use)) ? '0 : rn[ROW_W-1:0];
		end else begin
			col_next = cn[CW-1:0];
			row_next = r2;
		end

		produce = (WW'(c1) >= WW'(2)) && (r2 >= ROW_W'(2));
		last    = (WW'(c1) == w_use - WW'(1)) && (r2 == h_use - ROW_W'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			col_q <= col_next;
			row_q <= row_next;
		end
	end

	// line stores
	rgb_t          older_rdata, newer_rdata;
	rgb_t          up2, up1;
	logic [CW-1:0] col_s1;
	rgb_t          pix_s1;
	logic          prod_s1, last_s1, fwd_s1;
	rgb_t          fwd_older_s1, fwd_newer_s1;
	logic [9:0]    ccol_s1;
	logic [11:0]   crow_s1;

	bb3_ram #(.WIDTH(RGB_W), .DEPTH(MAX_LINE_PIXELS)) u_older (
		.clk  (clk),
		.we   (s1_go),
		.waddr(col_s1),
		.wdata(up1),
		.re   (accept),
		.raddr(c1),
		.rdata(older_rdata)
	);

	bb3_ram #(.WIDTH(RGB_W), .DEPTH(MAX_LINE_PIXELS)) u_newer (
		.clk  (clk),
		.we   (s1_go),
		.waddr(col_s1),
		.wdata(pix_s1),
		.re   (accept),
		.raddr(c1),
		.rdata(newer_rdata)
	);

	assign up2 = fwd_s1 ? fwd_older_s1 : older_rdata;
	assign up1 = fwd_s1 ? fwd_newer_s1 : newer_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_go) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1  <= c1;
			pix_s1  <= {pix_data.red_in, pix_data.green_in, pix_data.blue_in};
			prod_s1 <= produce;
			last_s1 <= last;
			ccol_s1 <= 10'(c1 - CW'(1));
			crow_s1 <= r2 - ROW_W'(1);
			// the store write of the word in s1 lands on this same edge
			fwd_s1       <= s1_go && (col_s1 == c1);
			fwd_older_s1 <= up1;
			fwd_newer_s1 <= pix_s1;
		end
	end

	// 3x3 window, [row 0=top][col 0=left]
	rgb_t win_q [3][3];
	rgb_t new_col [3];

	assign new_col[0] = up2;
	assign new_col[1] = up1;
	assign new_col[2] = pix_s1;

	always_ff @(posedge clk) begin
		if (s1_go) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= win_q[r][1];
				win_q[r][1] <= win_q[r][2];
				win_q[r][2] <= new_col[r];
			end
		end
	end

	logic [SUM_W-1:0] sum_r, sum_g, sum_b;

	always_comb begin
		sum_r = '0;
		sum_g = '0;
		sum_b = '0;
		for (int r = 0; r < 3; r++) begin
			sum_r = sum_r + SUM_W'(win_q[r][2].red) + SUM_W'(new_col[r].red);
			sum_g = sum_g + SUM_W'(win_q[r][2].green) + SUM_W'(new_col[r].green);
			sum_b = sum_b + SUM_W'(win_q[r][2].blue) + SUM_W'(new_col[r].blue);
			// middle column after the shift is the old right column; left is old middle
			sum_r = sum_r + SUM_W'(win_q[r][1].red);
			sum_g = sum_g + SUM_W'(win_q[r][1].green);
			sum_b = sum_b + SUM_W'(win_q[r][1].blue);
		end
	end

	// s2: sums
	logic [SUM_W-1:0] sum_r_s2, sum_g_s2, sum_b_s2;
	logic [9:0]       ccol_s2;
	logic [11:0]      crow_s2;
	logic             last_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
		end else if (s1_go) begin
			s2_valid_q <= prod_s1;
		end else if (s2_go) begin
			s2_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			sum_r_s2 <= sum_r;
			sum_g_s2 <= sum_g;
			sum_b_s2 <= sum_b;
			ccol_s2  <= ccol_s1;
			crow_s2  <= crow_s1;
			last_s2  <= last_s1;
		end
	end

	// divide by nine
	logic [2*SUM_W-1:0] prod_r, prod_g, prod_b;

	assign prod_r = (2*SUM_W)'(sum_r_s2) * (2*SUM_W)'(RECIP_NINE);
	assign prod_g = (2*SUM_W)'(sum_g_s2) * (2*SUM_W)'(RECIP_NINE);
	assign prod_b = (2*SUM_W)'(sum_b_s2) * (2*SUM_W)'(RECIP_NINE);

	res_word_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s2_go) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_go) begin
			out_q.red_avg    <= prod_r[RECIP_SHIFT +: 8];
			out_q.green_avg  <= prod_g[RECIP_SHIFT +: 8];
			out_q.blue_avg   <= prod_b[RECIP_SHIFT +: 8];
			out_q.center_col <= ccol_s2;
			out_q.center_row <= crow_s2;
			out_q.frame_last <= last_s2;
		end
	end

	assign res_valid = out_valid_q;
	assign res_data  = out_q;

	// checks
	a_col_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (WW'(col_q) < $past(w_use)))
		else $error("column counter left the line");

	a_s2_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && prod_s1) |=> s2_valid_q)
		else $error("interior pixel lost between s1 and s2");

	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_valid_q && out_valid_q && !res_ready) |=> s2_valid_q)
		else $error("s2 word dropped while output stalled");

	a_accept_room: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s1_valid_q) |-> s1_go)
		else $error("s1 overwritten before it moved on");

endmodule

### rtl/bb3_ram.sv
module bb3_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import bb3_pkg::*;

	localparam int LINE_MAX = 1024;
	localparam int MIN_WIDTH = 3;
	localparam int WINDOW_TAPS = 9;
	localparam int DRAIN_CYCLES = 10;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RAND_W_MAX = 12;
	localparam int PHASE_WORDS = 40;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  pix_valid = 1'b0;
	logic                  pix_ready;
	pix_word_t             pix_data = '0;
	logic                  res_valid;
	logic                  res_ready = 1'b0;
	res_word_t             res_data;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// model of the filter: two line stores, window, position, frame size
	rgb_t             two_up [LINE_MAX];
	rgb_t             one_up [LINE_MAX];
	rgb_t             win [3][3];
	int               col_pos = 0;
	int               row_pos = 0;
	logic [FW_W-1:0]  width_reg = FRAME_WIDTH_RST;
	logic [ROW_W-1:0] height_reg = FRAME_HEIGHT_RST;
	res_word_t        expected_blur [$];

	pix_word_t pixel_backlog [$];
	int        pix_queued = 0;
	int        pix_accepted = 0;
	logic      pix_took = 1'b0;
	int        send_idle = 0;
	int        recv_stall = 0;
	int        fails = 0;
	int        cycle_cnt = 0;

	box_blur_3x3_rgb dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix_data  (pix_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int used_width();
		if (width_reg < MIN_WIDTH) return MIN_WIDTH;
		if (width_reg > LINE_MAX) return LINE_MAX;
		return int'(width_reg);
	endfunction

	function automatic int used_height();
		return (height_reg < MIN_HEIGHT) ? int'(MIN_HEIGHT) : int'(height_reg);
	endfunction

	function automatic void box_average_step(pix_word_t w);
		int uw, uh, c, r, sr, sg, sb;
		rgb_t px;
		res_word_t e;
		uw = used_width();
		uh = used_height();
		px = {w.red_in, w.green_in, w.blue_in};
		if (w.frame_start) begin
			col_pos = 0;
			row_pos = 0;
		end
		// size may have shrunk since the last word
		if (col_pos >= uw) begin
			col_pos = 0;
			row_pos++;
		end
		if (row_pos >= uh) row_pos = 0;
		c = col_pos;
		r = row_pos;
		for (int i = 0; i < 3; i++) begin
			win[i][0] = win[i][1];
			win[i][1] = win[i][2];
		end
		win[0][2] = two_up[c];
		win[1][2] = one_up[c];
		win[2][2] = px;
		two_up[c] = one_up[c];
		one_up[c] = px;
		if (c >= 2 && r >= 2) begin
			sr = 0;
			sg = 0;
			sb = 0;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					sr += win[i][j].red;
					sg += win[i][j].green;
					sb += win[i][j].blue;
				end
			end
			e.red_avg = 8'(sr / WINDOW_TAPS);
			e.green_avg = 8'(sg / WINDOW_TAPS);
			e.blue_avg = 8'(sb / WINDOW_TAPS);
			e.center_col = 10'(c - 1);
			e.center_row = 12'(r - 1);
			e.frame_last = (c == uw - 1 && r == uh - 1);
			expected_blur.push_back(e);
		end
		col_pos = c + 1;
		if (col_pos >= uw) begin
			col_pos = 0;
			row_pos = r + 1;
			if (row_pos >= uh) row_pos = 0;
		end
	endfunction

	task automatic check_field(string name, logic [11:0] want, logic [11:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fails++;
		end
	endtask

	always @(posedge clk) begin : monitor
		res_word_t want;
		pix_took <= pix_valid && pix_ready;
		if (pix_valid && pix_ready) begin
			box_average_step(pix_data);
			pix_accepted <= pix_accepted + 1;
		end
		if (res_valid && res_ready) begin
			if (expected_blur.size() == 0) begin
				$error("unexpected word: col %0d row %0d", res_data.center_col,
					res_data.center_row);
				fails++;
			end else begin
				want = expected_blur.pop_front();
				check_field("red_avg", 12'(want.red_avg), 12'(res_data.red_avg));
				check_field("green_avg", 12'(want.green_avg), 12'(res_data.green_avg));
				check_field("blue_avg", 12'(want.blue_avg), 12'(res_data.blue_avg));
				check_field("center_col", 12'(want.center_col), 12'(res_data.center_col));
				check_field("center_row", want.center_row, res_data.center_row);
				check_field("frame_last", 12'(want.frame_last), 12'(res_data.frame_last));
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (!pix_valid || pix_took) begin
				if (pixel_backlog.size() != 0 && $urandom_range(99) >= send_idle) begin
					pix_valid <= 1'b1;
					pix_data <= pixel_backlog.pop_front();
				end else begin
					pix_valid <= 1'b0;
				end
			end
			res_ready <= ($urandom_range(99) >= recv_stall);
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic queue_word(pix_word_t w);
		pixel_backlog.push_back(w);
		pix_queued++;
	endtask

	// n pixels of random color, frame start on word fs_at (none if out of range)
	task automatic queue_run(int n, int fs_at);
		pix_word_t w;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(9))
				0: w = '0;
				1: w = {8'hFF, 8'hFF, 8'hFF, 1'b0};
				default: w = {8'($urandom), 8'($urandom), 8'($urandom), 1'b0};
			endcase
			w.frame_start = (i == fs_at);
			queue_word(w);
		end
	endtask

	// sender holds off until every expected word is back and the pipe is empty
	task automatic settle();
		do @(negedge clk); while (pix_accepted != pix_queued || expected_blur.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_FRAME_WIDTH) begin
			width_reg = val[FW_W-1:0];
		end else begin
			height_reg = val;
		end
		@(posedge clk);
	endtask

	initial begin
		int w, h, n, uw, uh, len, first_fs;
		for (int i = 0; i < LINE_MAX; i++) begin
			two_up[i] = '0;
			one_up[i] = '0;
		end
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) win[i][j] = '0;
		end
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset size: a few pixels into the first line, nothing comes out
		queue_run(16, 0);
		settle();

		set_reg(REG_FRAME_WIDTH, 12'd3);
		set_reg(REG_FRAME_HEIGHT, 12'd3);
		for (int i = 0; i < 9; i++) queue_word({8'hFF, 8'hFF, 8'hFF, i == 0});
		for (int i = 0; i < 9; i++) queue_word({8'hFF, 8'h00, 8'(i * 31), i == 0});
		// no frame start: counters wrap by themselves
		queue_run(9, -1);
		settle();

		// width beyond range saturates to the full line store
		set_reg(REG_FRAME_WIDTH, 12'hFFF);
		queue_run(20, 0);
		settle();

		// tall frame on the narrowest line; width 0 reads as 3
		set_reg(REG_FRAME_WIDTH, 12'h000);
		set_reg(REG_FRAME_HEIGHT, 12'hFFF);
		queue_run(3 * 7, 0);
		settle();

		// both line stores hold real pixels across the widest random line
		set_reg(REG_FRAME_WIDTH, 12'(RAND_W_MAX));
		set_reg(REG_FRAME_HEIGHT, 12'd3);
		queue_run(RAND_W_MAX * 3, 0);

		for (int p = 0; p < 4; p++) begin
			n = 0;
			while (n < PHASE_WORDS) begin
				settle();
				case (p)
					0: begin
						send_idle = 0;
						recv_stall = 0;
					end
					1: begin
						send_idle = 56;
						recv_stall = 0;
					end
					2: begin
						send_idle = 0;
						recv_stall = 56;
					end
					default: begin
						send_idle = 36;
						recv_stall = 36;
					end
				endcase
				w = ($urandom_range(9) == 0) ? $urandom_range(0, 2) :
					$urandom_range(3, RAND_W_MAX);
				h = ($urandom_range(9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 7);
				set_reg(REG_FRAME_WIDTH, 12'(w));
				set_reg(REG_FRAME_HEIGHT, 12'(h));
				uw = used_width();
				uh = used_height();
				// sometimes carry on in the current frame at the new size
				first_fs = ($urandom_range(3) == 0) ? -1 : 0;
				repeat ($urandom_range(1, 3)) begin
					len = uw * uh;
					case ($urandom_range(9))
						6: begin
							len = $urandom_range(1, uw * uh - 1);
							queue_run(len, first_fs);
						end
						7: queue_run(len, $urandom_range(1, len - 1));
						8: queue_run(len, -1);
						default: queue_run(len, first_fs);
					endcase
					n += len;
					first_fs = 0;
				end
				len = $urandom_range(0, 2 * uw);
				queue_run(len, -1);
				n += len;
			end
		end

		settle();
		if (fails == 0 && expected_blur.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

### files.f
rtl/bb3_pkg.sv
rtl/bb3_ram.sv
rtl/box_blur_3x3_rgb.sv
tb/sv/testbench.sv
